// ----- design/dsps_pkg.sv -----
// Package: shared types and constants of the delayed sort push scheduler.
`default_nettype none
package dsps_pkg;
    localparam int TASK_SLOTS = 10;
    localparam int BOXES      = 5;
    localparam int SLOT_W     = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
    localparam int BOX_W      = 3;
    localparam int IDX_W      = (BOXES > 1) ? $clog2(BOXES) : 1;

    localparam logic [7:0] FRAME_HEAD = 8'hAA;
    localparam logic [7:0] FRAME_TAIL = 8'h55;

    localparam logic [2:0] REG_FIRST   = 3'd0;
    localparam logic [2:0] REG_SPACING = 3'd1;
    localparam logic [2:0] REG_TRIMS   = 3'd2;
    localparam logic [2:0] REG_FWD     = 3'd3;
    localparam logic [2:0] REG_REV     = 3'd4;
    localparam logic [2:0] REG_NONE    = 3'd5;

    localparam logic [1:0] ACT_FWD  = 2'd0;
    localparam logic [1:0] ACT_REV  = 2'd1;
    localparam logic [1:0] ACT_STOP = 2'd2;

    // datapath commands from the controller
    typedef struct packed {
        logic                take_byte;  // run the parser on the input byte
        logic                place;      // store the pending frame at slot_idx
        logic                advance;    // clock_ms += 1
        logic                servo_chk;  // service servo servo_idx
        logic                slot_chk;   // service slot slot_idx
        logic                emit;       // move the staged result word to the output
        logic [IDX_W-1:0]    servo_idx;
        logic [SLOT_W-1:0]   slot_idx;
    } t_cmd;

    // datapath status to the controller
    typedef struct packed {
        logic frame_done;   // a good frame is pending placement
        logic servo_hit;    // selected servo produces a result
        logic slot_hit;     // selected slot produces a result
        logic slot_free;    // selected slot is free
    } t_status;
endpackage
`default_nettype wire

// ----- design/dsps_datapath.sv -----
// Datapath: parser, configuration, task table, servo state and result word.
`default_nettype none
module dsps_datapath (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_valid,
    input  wire logic [2:0]           i_cfg_index,
    input  wire logic [59:0]          i_cfg_data,
    input  wire logic [7:0]           i_byte,
    input  wire dsps_pkg::t_cmd       i_cmd,
    output dsps_pkg::t_status         o_status,
    output logic [2:0]                o_servo_index,
    output logic [1:0]                o_servo_action,
    output logic [15:0]               o_box_count
);
    import dsps_pkg::*;

    typedef enum logic [1:0] {PH_HEAD, PH_ID, PH_TAIL} t_phase;

    logic [15:0] r_first, r_spacing, r_fwd, r_rev;
    logic [59:0] r_trims;
    t_phase      r_phase;
    logic [7:0]  r_pending;
    logic        r_frame;
    logic [31:0] r_clock;
    logic [31:0] r_delay;
    logic [TASK_SLOTS-1:0] r_sv;
    logic [BOX_W-1:0]      r_sbox [TASK_SLOTS];
    logic [31:0]           r_sdue [TASK_SLOTS];
    logic [BOXES-1:0]      r_busy;
    logic [BOXES-1:0]      r_fwdph;
    logic [31:0]           r_vdue [BOXES];
    logic [15:0]           r_cnt  [BOXES];
    logic [2:0]            r_st_idx;
    logic [1:0]            r_st_act;
    logic [15:0]           r_st_cnt;

    logic [IDX_W-1:0]  sel_i;
    logic [SLOT_W-1:0] sel_s;
    logic [IDX_W-1:0]  tsrv;
    logic              box_ok;
    logic              slot_due_ok, servo_due_ok;
    logic [31:0]       sdue_v, vdue_v, sd_diff, vd_diff;
    logic [2:0]        id_m1;
    logic signed [11:0] trim;
    logic [18:0]       span;
    logic signed [20:0] dsum;

    // trim and delay of the pending id (registered when the frame completes)
    always_comb begin
        id_m1 = r_pending[2:0] - 3'd1;
        case (id_m1)
            3'd0:    trim = r_trims[11:0];
            3'd1:    trim = r_trims[23:12];
            3'd2:    trim = r_trims[35:24];
            3'd3:    trim = r_trims[47:36];
            3'd4:    trim = r_trims[59:48];
            default: trim = 12'sd0;
        endcase
        span = 19'(r_spacing) * 19'(id_m1);
        dsum = $signed({5'd0, r_first}) + $signed({2'd0, span}) + 21'(trim);
    end

    assign sel_i = i_cmd.servo_idx;
    assign sel_s = i_cmd.slot_idx;
    always_comb begin
        sdue_v = r_sdue[sel_s];
        vdue_v = r_vdue[sel_i];
        sd_diff = r_clock - sdue_v;
        vd_diff = r_clock - vdue_v;
        slot_due_ok  = !sd_diff[31];
        servo_due_ok = !vd_diff[31];
        tsrv   = IDX_W'(r_sbox[sel_s] - 3'd1);
        box_ok = r_sbox[sel_s] >= 3'd1 && r_sbox[sel_s] <= BOX_W'(BOXES);
    end

    always_comb begin
        o_status.frame_done = r_frame;
        o_status.servo_hit  = r_busy[sel_i] && servo_due_ok;
        o_status.slot_free  = !r_sv[sel_s];
        o_status.slot_hit   = r_sv[sel_s] && slot_due_ok && box_ok && !r_busy[tsrv];
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first <= 16'd8750; r_spacing <= 16'd10500;
            r_trims <= 60'd1099427782656; r_fwd <= 16'd1000; r_rev <= 16'd1000;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_FIRST:   r_first   <= i_cfg_data[15:0];
                REG_SPACING: r_spacing <= i_cfg_data[15:0];
                REG_TRIMS:   r_trims   <= i_cfg_data;
                REG_FWD:     r_fwd     <= i_cfg_data[15:0];
                REG_REV:     r_rev     <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // parser, table and servo state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEAD; r_pending <= 8'd0; r_frame <= 1'b0;
            r_clock <= 32'd0; r_sv <= '0; r_busy <= '0; r_fwdph <= '0;
            for (int k = 0; k < BOXES; k++) begin
                r_cnt[k] <= 16'd0; r_vdue[k] <= 32'd0;
            end
        end else begin
            if (i_cmd.take_byte) begin
                r_frame <= 1'b0;
                unique case (r_phase)
                    PH_HEAD: if (i_byte == FRAME_HEAD) r_phase <= PH_ID;
                    PH_ID: begin
                        r_pending <= i_byte; r_phase <= PH_TAIL;
                    end
                    PH_TAIL: begin
                        r_frame <= (i_byte == FRAME_TAIL) && r_pending >= 8'd1
                                   && r_pending <= 8'(BOXES);
                        r_delay <= dsum[20] ? 32'd0 : {12'd0, dsum[19:0]};
                        r_phase <= PH_HEAD;
                    end
                    default: r_phase <= PH_HEAD;
                endcase
            end
            if (i_cmd.place) begin
                r_frame <= 1'b0;
                r_sv[sel_s]   <= 1'b1;
                r_sbox[sel_s] <= r_pending[2:0];
                r_sdue[sel_s] <= r_clock + r_delay;
            end
            if (i_cmd.advance) r_clock <= r_clock + 32'd1;
            // move the staged word to the output register
            if (i_cmd.emit) begin
                o_servo_index  <= r_st_idx;
                o_servo_action <= r_st_act;
                o_box_count    <= r_st_cnt;
            end
            if (i_cmd.servo_chk && o_status.servo_hit) begin
                r_st_idx <= BOX_W'(sel_i);
                r_st_cnt <= r_cnt[sel_i];
                if (r_fwdph[sel_i]) begin
                    r_fwdph[sel_i] <= 1'b0;
                    r_vdue[sel_i]  <= r_clock + {16'd0, r_rev};
                    r_st_act       <= ACT_REV;
                end else begin
                    r_busy[sel_i]  <= 1'b0;
                    r_st_act       <= ACT_STOP;
                end
            end
            if (i_cmd.slot_chk && r_sv[sel_s] && slot_due_ok
                && !(box_ok && r_busy[tsrv])) begin
                r_sv[sel_s] <= 1'b0;
                if (box_ok) begin
                    r_busy[tsrv]  <= 1'b1;
                    r_fwdph[tsrv] <= 1'b1;
                    r_vdue[tsrv]  <= r_clock + {16'd0, r_fwd};
                    r_cnt[tsrv]   <= r_cnt[tsrv] + 16'd1;
                    r_st_idx      <= BOX_W'(tsrv);
                    r_st_act      <= ACT_FWD;
                    r_st_cnt      <= r_cnt[tsrv] + 16'd1;
                end
            end
        end
    end
endmodule
`default_nettype wire

// ----- design/dsps_ctrl.sv -----
// Controller: sequences byte handling, slot search and the per-tick service scan.
`default_nettype none
module dsps_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire logic              i_command,
    output logic                   o_stall,
    input  wire dsps_pkg::t_status i_status,
    output dsps_pkg::t_cmd         o_cmd,
    output logic                   o_valid,
    output logic                   o_last,
    input  wire logic              i_out_stall
);
    import dsps_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_FIND, S_SERVO, S_SLOT, S_OUT} t_state;

    t_state            r_state;
    logic [IDX_W-1:0]  r_si;
    logic [SLOT_W-1:0] r_ti;
    logic              r_pend;       // a result is staged but its last flag unknown
    logic              hit;
    logic              out_free;
    logic              go;

    assign o_stall  = (r_state != S_IDLE);
    assign out_free = !o_valid || !i_out_stall;
    assign hit = (r_state == S_SERVO) ? i_status.servo_hit : i_status.slot_hit;
    // a new hit waits until the older staged word can move to the output
    assign go  = !(hit && r_pend && !out_free);

    always_comb begin
        o_cmd = '0;
        o_cmd.servo_idx = r_si;
        o_cmd.slot_idx  = r_ti;
        unique case (r_state)
            S_IDLE:  begin
                o_cmd.take_byte = i_valid && !i_command;
                o_cmd.advance   = i_valid && i_command;
            end
            S_FIND:  o_cmd.place = i_status.frame_done && i_status.slot_free;
            S_SERVO: begin
                o_cmd.servo_chk = go;
                o_cmd.emit      = go && hit && r_pend;
            end
            S_SLOT:  begin
                o_cmd.slot_chk = go;
                o_cmd.emit     = go && hit && r_pend;
            end
            S_OUT:   o_cmd.emit = r_pend && out_free;
            default: ;
        endcase
    end

    // scan an entry per cycle unless held; staged word leaves at a later hit or scan end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_si <= '0; r_ti <= '0; o_valid <= 1'b0;
            o_last <= 1'b0; r_pend <= 1'b0;
        end else begin
            if (o_cmd.emit) begin
                o_valid <= 1'b1;
                o_last  <= (r_state == S_OUT);
            end else if (!i_out_stall) begin
                o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: if (i_valid) begin
                    r_si <= '0; r_ti <= '0;
                    r_state <= i_command ? S_SERVO : S_FIND;
                end
                S_FIND: begin
                    if (!i_status.frame_done || i_status.slot_free
                        || r_ti == SLOT_W'(TASK_SLOTS - 1)) r_state <= S_IDLE;
                    else r_ti <= r_ti + 1'b1;
                end
                S_SERVO: if (go) begin
                    if (hit) r_pend <= 1'b1;
                    if (r_si == IDX_W'(BOXES - 1)) r_state <= S_SLOT;
                    else r_si <= r_si + 1'b1;
                end
                S_SLOT: if (go) begin
                    if (hit) r_pend <= 1'b1;
                    if (r_ti == SLOT_W'(TASK_SLOTS - 1)) r_state <= S_OUT;
                    else r_ti <= r_ti + 1'b1;
                end
                S_OUT: if (!r_pend || out_free) begin
                    r_pend  <= 1'b0;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ----- design/delayed_sort_push_scheduler.sv -----
// Top level: delayed sort push scheduler.
// Input channel carries a word of command and rx_byte: command 0 feeds the
// serial frame parser (0xAA, box id, 0x55), command 1 is a millisecond tick.
// Output channel carries one word per servo command issued by a tick, with
// last set on the final word of that tick; bytes and quiet ticks give none.
// Configuration writes (index 0..4) go through the cfg channel; the user must
// write only while idle, as the block itself does not enforce it. A byte is
// parsed as it is accepted; the controller then visits its find state, where
// a complete frame searches the task table one slot per cycle, before the
// next word is taken. A tick scans the servos and then the task slots, one
// entry per cycle unless held as below, and then passes its output state
// before the next word is taken. Each result is staged until a later hit or
// the scan end shows whether it is last.
// When the receiver stalls, the scan holds at the next hit, and at the scan
// end, until the output register drains.
// Synchronous reset clears the parser, clock, task table and servo state
// and restores the configuration defaults.
`default_nettype none
module delayed_sort_push_scheduler (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic        i_command,
    input  wire logic [7:0]  i_rx_byte,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [2:0]       o_servo_index,
    output logic [1:0]       o_servo_action,
    output logic [15:0]      o_box_count,
    output logic             o_last,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [59:0] i_cfg_data
);
    import dsps_pkg::*;

    t_cmd       cmd;
    t_status    status;

    assign o_cfg_ready = 1'b1;

    dsps_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_command(i_command),
        .o_stall(o_stall), .i_status(status), .o_cmd(cmd), .o_valid(o_valid),
        .o_last(o_last), .i_out_stall(i_stall)
    );

    dsps_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_valid(i_cfg_valid),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data), .i_byte(i_rx_byte),
        .i_cmd(cmd), .o_status(status), .o_servo_index(o_servo_index),
        .o_servo_action(o_servo_action), .o_box_count(o_box_count)
    );
endmodule
`default_nettype wire

// ----- tb/dsps_checker.sv -----
// Checker: watches the scheduler channels, predicts servo words and compares them.
module dsps_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    input  wire logic        i_stall_in,
    input  wire logic        i_command,
    input  wire logic [7:0]  i_rx_byte,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_stall,
    input  wire logic [2:0]  i_servo_index,
    input  wire logic [1:0]  i_servo_action,
    input  wire logic [15:0] i_box_count,
    input  wire logic        i_last,
    input  wire logic        i_cfg_valid,
    input  wire logic        i_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [59:0] i_cfg_data,
    output int               o_errors,
    output int               o_outstanding
);
    import dsps_pkg::*;

    typedef struct packed {
        logic [2:0]  idx;
        logic [1:0]  act;
        logic [15:0] cnt;
        logic        last;
    } t_servo_word;

    typedef enum logic [1:0] {WAIT_HEAD, WAIT_ID, WAIT_TAIL} t_parse;
    typedef enum logic [1:0] {MOTOR_IDLE, MOTOR_FWD, MOTOR_REV} t_motor;

    t_servo_word servo_words_q[$];
    int          err_cnt;

    logic [15:0] first_delay, spacing, fwd_ms, rev_ms;
    logic [59:0] trims;
    t_parse      parse_st;
    logic [7:0]  held_id;
    logic [31:0] now_ms;
    logic        task_live [TASK_SLOTS];
    logic [2:0]  task_box  [TASK_SLOTS];
    logic [31:0] task_due  [TASK_SLOTS];
    logic        motor_busy [BOXES];
    t_motor      motor_st   [BOXES];
    logic [31:0] motor_due  [BOXES];
    logic [15:0] pushes     [BOXES];

    assign o_errors      = err_cnt;
    assign o_outstanding = servo_words_q.size();

    function automatic bit is_reached(logic [31:0] now, logic [31:0] due);
        logic [31:0] diff;
        diff = now - due;
        return !diff[31];
    endfunction

    function automatic void clear_model();
        first_delay = 16'd8750;
        spacing     = 16'd10500;
        trims       = 60'd1099427782656;
        fwd_ms      = 16'd1000;
        rev_ms      = 16'd1000;
        parse_st    = WAIT_HEAD;
        held_id     = '0;
        now_ms      = '0;
        for (int i = 0; i < TASK_SLOTS; i++) begin
            task_live[i] = 1'b0;
            task_box[i]  = '0;
            task_due[i]  = '0;
        end
        for (int i = 0; i < BOXES; i++) begin
            motor_busy[i] = 1'b0;
            motor_st[i]   = MOTOR_IDLE;
            motor_due[i]  = '0;
            pushes[i]     = '0;
        end
    endfunction

    function automatic void write_reg(logic [2:0] idx, logic [59:0] data);
        case (idx)
            REG_FIRST:   first_delay = data[15:0];
            REG_SPACING: spacing     = data[15:0];
            REG_TRIMS:   trims       = data;
            REG_FWD:     fwd_ms      = data[15:0];
            REG_REV:     rev_ms      = data[15:0];
            default: ;
        endcase
    endfunction

    // store a completed frame in the lowest free slot, drop when full
    function automatic void store_frame(logic [7:0] id);
        logic signed [11:0] trim;
        longint             delay;
        if (id < 1 || id > BOXES) return;
        trim  = trims[12*(id-1) +: 12];
        delay = longint'(first_delay) + longint'(id - 1) * longint'(spacing)
              + longint'(trim);
        if (delay < 0) delay = 0;
        for (int i = 0; i < TASK_SLOTS; i++) begin
            if (!task_live[i]) begin
                task_live[i] = 1'b1;
                task_box[i]  = id[2:0];
                task_due[i]  = now_ms + 32'(delay);
                return;
            end
        end
    endfunction

    function automatic void queue_word(int s, logic [1:0] act);
        t_servo_word w;
        w.idx  = 3'(s);
        w.act  = act;
        w.cnt  = pushes[s];
        w.last = 1'b0;
        servo_words_q.push_back(w);
    endfunction

    // advance the model by one accepted input word
    function automatic void predict_word(logic cmd, logic [7:0] b);
        int first_new;
        int s;
        if (!cmd) begin
            case (parse_st)
                WAIT_HEAD: if (b == FRAME_HEAD) parse_st = WAIT_ID;
                WAIT_ID: begin
                    held_id  = b;
                    parse_st = WAIT_TAIL;
                end
                WAIT_TAIL: begin
                    if (b == FRAME_TAIL) store_frame(held_id);
                    parse_st = WAIT_HEAD;
                end
                default: parse_st = WAIT_HEAD;
            endcase
            return;
        end
        first_new = servo_words_q.size();
        now_ms    = now_ms + 32'd1;
        // servo pass: forward turns to reverse, reverse stops
        for (int i = 0; i < BOXES; i++) begin
            if (motor_busy[i] && is_reached(now_ms, motor_due[i])) begin
                if (motor_st[i] == MOTOR_FWD) begin
                    motor_st[i]  = MOTOR_REV;
                    motor_due[i] = now_ms + {16'd0, rev_ms};
                    queue_word(i, ACT_REV);
                end else begin
                    motor_busy[i] = 1'b0;
                    motor_st[i]   = MOTOR_IDLE;
                    queue_word(i, ACT_STOP);
                end
            end
        end
        // task pass: start due tasks whose servo is free
        for (int i = 0; i < TASK_SLOTS; i++) begin
            if (task_live[i] && is_reached(now_ms, task_due[i])) begin
                s = task_box[i] - 1;
                if (!motor_busy[s]) begin
                    motor_busy[s] = 1'b1;
                    motor_st[s]   = MOTOR_FWD;
                    motor_due[s]  = now_ms + {16'd0, fwd_ms};
                    pushes[s]     = pushes[s] + 16'd1;
                    queue_word(s, ACT_FWD);
                    task_live[i]  = 1'b0;
                end
            end
        end
        if (servo_words_q.size() > first_new)
            servo_words_q[servo_words_q.size()-1].last = 1'b1;
    endfunction

    // compare the output word against the oldest prediction
    always @(posedge i_clk) begin
        t_servo_word w;
        if (!i_rst_n) begin
            clear_model();
            servo_words_q.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (servo_words_q.size() == 0) begin
                    $error("unexpected servo word idx=%0d act=%0d",
                           i_servo_index, i_servo_action);
                    err_cnt++;
                end else begin
                    w = servo_words_q.pop_front();
                    if (i_servo_index !== w.idx) begin
                        $error("servo_index: expected %0d, actual %0d", w.idx, i_servo_index);
                        err_cnt++;
                    end
                    if (i_servo_action !== w.act) begin
                        $error("servo_action: expected %0d, actual %0d", w.act, i_servo_action);
                        err_cnt++;
                    end
                    if (i_box_count !== w.cnt) begin
                        $error("box_count: expected %0d, actual %0d", w.cnt, i_box_count);
                        err_cnt++;
                    end
                    if (i_last !== w.last) begin
                        $error("last: expected %0d, actual %0d", w.last, i_last);
                        err_cnt++;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) write_reg(i_cfg_index, i_cfg_data);
            if (i_valid && !i_stall_in) predict_word(i_command, i_rx_byte);
        end
    end

    initial err_cnt = 0;
endmodule

// ----- tb/tb_top.sv -----
// Testbench top: drives bytes, ticks and register writes into the scheduler.
module tb_top;
    import dsps_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic        i_command = 1'b0;
    logic [7:0]  i_rx_byte = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [2:0]  o_servo_index;
    logic [1:0]  o_servo_action;
    logic [15:0] o_box_count;
    logic        o_last;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [59:0] i_cfg_data = '0;
    int          fail_cnt;
    int          pending;
    logic        steady = 1'b0;

    delayed_sort_push_scheduler dut (.*);

    dsps_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_stall_in(o_stall),
        .i_command(i_command), .i_rx_byte(i_rx_byte), .i_out_valid(o_valid),
        .i_out_stall(i_stall), .i_servo_index(o_servo_index),
        .i_servo_action(o_servo_action), .i_box_count(o_box_count), .i_last(o_last),
        .i_cfg_valid(i_cfg_valid), .i_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_errors(fail_cnt), .o_outstanding(pending)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #4000000;
        $display("tb: failure");
        $finish;
    end

    // stall the output at random, except during the steady stretch
    always @(posedge i_clk) begin
        i_stall <= steady ? 1'b0 : ($urandom_range(99) < 24);
    end

    // send one word and hold it until accepted, then maybe idle
    task automatic feed(input logic cmd, input logic [7:0] b);
        i_valid   <= 1'b1;
        i_command <= cmd;
        i_rx_byte <= b;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        if (!steady && $urandom_range(99) < 24) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
    endtask

    task automatic frame(input logic [7:0] id, input logic [7:0] tail);
        feed(1'b0, FRAME_HEAD);
        feed(1'b0, id);
        feed(1'b0, tail);
    endtask

    task automatic ticks(input int n);
        repeat (n) feed(1'b1, 8'($urandom));
    endtask

    // hold the sender until every predicted word has drained
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [59:0] data);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [59:0] pack_trims(int t0, int t1, int t2, int t3, int t4);
        return {12'(t4), 12'(t3), 12'(t2), 12'(t1), 12'(t0)};
    endfunction

    // random timing setup with short delays so tasks fire within the run
    task automatic shuffle_setup();
        int t[5];
        for (int k = 0; k < 5; k++)
            t[k] = ($urandom_range(9) == 0) ? -2048 : $signed($urandom_range(16)) - 8;
        write_reg(REG_FIRST,   60'($urandom_range(0, 6)));
        write_reg(REG_SPACING, 60'($urandom_range(0, 3)));
        write_reg(REG_TRIMS,   pack_trims(t[0], t[1], t[2], t[3], t[4]));
        write_reg(REG_FWD,     60'($urandom_range(0, 4)));
        write_reg(REG_REV,     60'($urandom_range(0, 4)));
    endtask

    // mostly well-formed frames and ticks, with some noise and broken frames
    task automatic random_run(input int n);
        int r;
        int done;
        logic [7:0] id;
        done = 0;
        while (done < n) begin
            r = $urandom_range(99);
            if (r < 45) begin
                id = ($urandom_range(9) < 8) ? 8'($urandom_range(1, 5)) : 8'($urandom);
                frame(id, ($urandom_range(9) == 0) ? 8'($urandom) : FRAME_TAIL);
                done += 3;
            end else if (r < 90) begin
                r = $urandom_range(1, 4);
                ticks(r);
                done += r;
            end else begin
                feed(1'b0, 8'($urandom));
                done += 1;
            end
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // defaults: an invalid id and a broken trailer only
        frame(8'h00, FRAME_TAIL);
        frame(8'h03, 8'h54);
        ticks(2);

        // short delays, negative trim on box one clamps to zero
        write_reg(REG_FIRST, 60'd0);
        write_reg(REG_SPACING, 60'd1);
        write_reg(REG_TRIMS, pack_trims(-5, 2, 0, -1, 3));
        write_reg(REG_FWD, 60'd2);
        write_reg(REG_REV, 60'd1);
        write_reg(REG_NONE, 60'hFFF_FFFF_FFFF_FFFF);
        frame(8'd1, FRAME_TAIL);
        frame(8'd5, FRAME_TAIL);
        frame(8'd6, FRAME_TAIL);
        frame(8'hFF, FRAME_TAIL);
        feed(1'b0, FRAME_HEAD);
        frame(8'd2, FRAME_TAIL);
        ticks(6);
        frame(8'd1, FRAME_TAIL);
        ticks(8);

        // extremes: spacing max with box one only, all-negative trims
        write_reg(REG_FIRST, 60'd0);
        write_reg(REG_SPACING, 60'hFFFF);
        write_reg(REG_TRIMS, pack_trims(-2048, -2048, -2048, -2048, -2048));
        write_reg(REG_FWD, 60'd0);
        write_reg(REG_REV, 60'd0);
        frame(8'd1, FRAME_TAIL);
        frame(8'd1, FRAME_TAIL);
        ticks(6);

        // extremes: maximum delays and durations with no frames placed
        write_reg(REG_FIRST, 60'hFFFF);
        write_reg(REG_TRIMS, 60'hFFF_FFFF_FFFF_FFFF);
        write_reg(REG_FWD, 60'hFFFF);
        write_reg(REG_REV, 60'hFFFF);
        frame(8'd0, FRAME_TAIL);
        ticks(3);

        // fill the task table past its capacity, then drain it
        write_reg(REG_FIRST, 60'd3);
        write_reg(REG_SPACING, 60'd0);
        write_reg(REG_TRIMS, 60'd0);
        write_reg(REG_FWD, 60'd0);
        write_reg(REG_REV, 60'd0);
        for (int k = 0; k < TASK_SLOTS + 2; k++) frame(8'($urandom_range(1, 5)), FRAME_TAIL);
        ticks(40);

        shuffle_setup();
        random_run(25);
        shuffle_setup();
        steady <= 1'b1;
        random_run(25);
        steady <= 1'b0;
        shuffle_setup();
        random_run(30);
        ticks(10);

        drain();
        if (fail_cnt == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
